// ===== sv/jis_pkg.sv =====
package jis_pkg;
   localparam int MaxUnknowns = 16;
   localparam int IdxBits = 4;
   localparam int AddrBits = 8;
   localparam int ValueBits = 32;
   localparam int NumBits = 48;
   localparam int QuoBits = NumBits + 16;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NOCONV = 2'd1;
   localparam logic [1:0] STATUS_ZERODIAG = 2'd2;

   localparam logic [1:0] CSR_TOLERANCE = 2'd0;
   localparam logic [1:0] CSR_SWEEP_LIMIT = 2'd1;
   localparam logic [1:0] CSR_SIZE = 2'd2;

   typedef struct packed {
      logic start;
      logic signed [QuoBits-1:0] dividend;
      logic signed [ValueBits-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic signed [ValueBits-1:0] quotient;
   } div_rsp_type;
endpackage

// ===== sv/jis_divider.sv =====
// Restoring signed divider, one quotient bit per cycle, truncating toward zero,
// result saturated to the value width.
module jis_divider import jis_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   localparam int DvdBits = QuoBits;

   logic [DvdBits-1:0] quo_ff, quo_in;
   logic [DvdBits:0] rem_ff, rem_in;
   logic [ValueBits:0] dsr_ff, dsr_in;
   logic neg_ff, neg_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic signed [ValueBits-1:0] res_ff, res_in;

   logic [DvdBits:0] shifted;
   logic [DvdBits:0] trial;
   logic signed [DvdBits+1:0] signed_q;

   always_comb begin
      shifted = {rem_ff[DvdBits-1:0], quo_ff[DvdBits-1]};
      trial = shifted - {{(DvdBits-ValueBits){1'b0}}, dsr_ff};
      signed_q = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
   end

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      res_in = res_ff;
      if (req.start) begin
         quo_in = req.dividend[DvdBits-1] ? DvdBits'(-req.dividend) : req.dividend;
         dsr_in = req.divisor[ValueBits-1] ?
                  -{req.divisor[ValueBits-1], req.divisor} : {1'b0, req.divisor};
         neg_in = req.dividend[DvdBits-1] ^ req.divisor[ValueBits-1];
         rem_in = '0;
         cnt_in = 7'(DvdBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (signed_q > $signed({{(DvdBits+2-ValueBits){1'b0}}, {1'b0, {(ValueBits-1){1'b1}}}}))
               res_in = {1'b0, {(ValueBits-1){1'b1}}};
            else if (signed_q < -$signed({{(DvdBits+2-ValueBits){1'b0}}, 1'b1, {(ValueBits-1){1'b0}}}))
               res_in = {1'b1, {(ValueBits-1){1'b0}}};
            else
               res_in = signed_q[ValueBits-1:0];
         end else begin
            cnt_in = cnt_ff - 7'd1;
            if (!trial[DvdBits]) begin
               rem_in = trial;
               quo_in = {quo_ff[DvdBits-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[DvdBits-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = res_ff;
endmodule

// ===== sv/jacobi_iteration_solver.sv =====
// Jacobi solver for up to 16 unknowns in signed Q16.16. Load items are taken one per
// cycle; the item flagged final_item starts a solve, and req_stall stays high until its
// results are sent. A diagonal check comes first. Each row of a sweep has a setup step,
// a pass through the shared 32x32 multiplier (one term per cycle) and a division in the
// shared divider; a sweep ends with the estimate update and the convergence check. The
// whole solve is up to sweep_limit sweeps (at least one if no diagonal is zero), then n
// results are sent one per cycle as the output side allows. Coefficients sit in a
// 256-entry memory read one word per cycle.
module jacobi_iteration_solver import jis_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_op,
   input  logic [3:0]                  req_row,
   input  logic [3:0]                  req_col,
   input  logic signed [31:0]          req_value,
   input  logic                        req_final_item,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [3:0]                  rsp_index,
   output logic signed [31:0]          rsp_solution,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_last_result,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [31:0]                 csr_data
);
   typedef enum logic [9:0] {
      ST_LOAD  = 10'b0000000001,
      ST_DIAG  = 10'b0000000010,
      ST_DIAGW = 10'b0000000100,
      ST_ROW   = 10'b0000001000,
      ST_MAC   = 10'b0000010000,
      ST_DIVW  = 10'b0000100000,
      ST_COPY  = 10'b0001000000,
      ST_CHECK = 10'b0010000000,
      ST_EMIT  = 10'b0100000000,
      ST_DRAIN = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [30:0] tol_ff;
   logic [9:0] limit_ff;
   logic [4:0] size_ff;
   logic [4:0] n_eff;

   // coefficient and right-hand side memories
   logic signed [ValueBits-1:0] coef_mem [0:MaxUnknowns*MaxUnknowns-1];
   logic signed [ValueBits-1:0] rhs_mem [0:MaxUnknowns-1];
   logic signed [ValueBits-1:0] coef_rd_ff;
   logic signed [ValueBits-1:0] rhs_rd_ff;
   logic [AddrBits-1:0] rd_addr;

   logic signed [ValueBits-1:0] cur_ff [0:MaxUnknowns-1];
   logic signed [ValueBits-1:0] nxt_ff [0:MaxUnknowns-1];

   logic [IdxBits-1:0] i_ff, i_in;
   logic [4:0] j_ff, j_in;
   logic [IdxBits-1:0] jd_ff;          // column of the word now in coef_rd_ff
   logic jv_ff;                         // coef_rd_ff holds a usable term
   logic signed [63:0] prod_ff;
   logic pv_ff;
   logic signed [NumBits+2:0] acc_ff, acc_in;
   logic signed [ValueBits-1:0] diag_ff, diag_in;
   logic zero_diag_ff, zero_diag_in;
   logic [9:0] sweep_ff, sweep_in;
   logic [ValueBits-1:0] chg_ff, chg_in;
   logic [1:0] status_ff, status_in;
   logic flush_ff, flush_in;

   div_req_type dreq;
   div_rsp_type drsp;

   logic rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_index_ff, rsp_index_in;
   logic signed [31:0] rsp_sol_ff, rsp_sol_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic rsp_last_ff, rsp_last_in;

   logic req_take;
   logic signed [ValueBits:0] delta;
   logic [ValueBits-1:0] delta_abs;
   logic signed [NumBits+2:0] clamped;
   logic [IdxBits-1:0] last_idx;

   assign n_eff = (size_ff == 5'd0) ? 5'd1 : ((size_ff > 5'd16) ? 5'd16 : size_ff);
   assign last_idx = IdxBits'(n_eff - 5'd1);
   assign req_stall = (state_ff != ST_LOAD);
   assign req_take = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= 31'd66;
         limit_ff <= 10'd50;
         size_ff <= 5'd16;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TOLERANCE: tol_ff <= csr_data[30:0];
            CSR_SWEEP_LIMIT: limit_ff <= csr_data[9:0];
            CSR_SIZE: size_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // memory read address: diagonal check walks j along the diagonal, sweeps walk row i column j
   always_comb begin
      if (state_ff == ST_DIAG || state_ff == ST_DIAGW)
         rd_addr = {j_ff[IdxBits-1:0], j_ff[IdxBits-1:0]};
      else
         rd_addr = {i_ff, j_ff[IdxBits-1:0]};
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         if (!req_op) coef_mem[{req_row, req_col}] <= req_value;
         else rhs_mem[req_row] <= req_value;
      end
      coef_rd_ff <= coef_mem[rd_addr];
      rhs_rd_ff <= rhs_mem[i_ff];
   end

   // multiplier stage
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= jv_ff && (jd_ff != i_ff) && (state_ff == ST_MAC);
      end
      prod_ff <= coef_rd_ff * cur_ff[jd_ff];
   end

   jis_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   always_comb begin
      if (acc_ff > $signed((NumBits+3)'(64'sd1 <<< 46)))
         clamped = (NumBits+3)'(64'sd1 <<< 46);
      else if (acc_ff < -$signed((NumBits+3)'(64'sd1 <<< 46)))
         clamped = -$signed((NumBits+3)'(64'sd1 <<< 46));
      else
         clamped = acc_ff;
      dreq.start = (state_ff == ST_MAC) && flush_ff && !pv_ff;
      dreq.dividend = {clamped[NumBits-1:0], 16'd0};
      dreq.divisor = diag_ff;
      delta = $signed({cur_ff[i_ff][ValueBits-1], cur_ff[i_ff]})
              - $signed({nxt_ff[i_ff][ValueBits-1], nxt_ff[i_ff]});
      delta_abs = delta[ValueBits] ? ValueBits'(-delta) : delta[ValueBits-1:0];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      acc_in = acc_ff;
      diag_in = diag_ff;
      zero_diag_in = zero_diag_ff;
      sweep_in = sweep_ff;
      chg_in = chg_ff;
      status_in = status_ff;
      flush_in = flush_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_sol_in = rsp_sol_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in = rsp_last_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take && req_final_item) begin
               state_in = ST_DIAG;
               j_in = '0;
               zero_diag_in = 1'b0;
               sweep_in = '0;
               chg_in = '0;
            end
         end
         ST_DIAG: begin
            // issue diagonal reads; word for j arrives in the next cycle
            if (j_ff == n_eff) state_in = ST_DIAGW;
            else j_in = j_ff + 5'd1;
            if (jv_ff && coef_rd_ff == '0) zero_diag_in = 1'b1;
         end
         ST_DIAGW: begin
            if (jv_ff && coef_rd_ff == '0) zero_diag_in = 1'b1;
            if (!jv_ff) begin
               i_in = '0;
               if (zero_diag_ff) begin
                  status_in = STATUS_ZERODIAG;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_ROW;
               end
            end
         end
         ST_ROW: begin
            j_in = '0;
            flush_in = 1'b0;
            chg_in = (i_ff == '0) ? '0 : chg_ff;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            // right-hand side word for row i is ready on the first term cycle
            if (j_ff == 5'd0)
               acc_in = $signed({{(NumBits+3-ValueBits){rhs_rd_ff[ValueBits-1]}},
                                 rhs_rd_ff});
            if (jv_ff && jd_ff == i_ff) diag_in = coef_rd_ff;
            if (pv_ff)
               acc_in = acc_ff - $signed((NumBits+3)'(prod_ff >>> 16));
            if (j_ff == n_eff) flush_in = 1'b1;
            else j_in = j_ff + 5'd1;
            if (dreq.start) state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (drsp.done) begin
               if (i_ff == last_idx) begin
                  i_in = '0;
                  state_in = ST_COPY;
               end else begin
                  i_in = i_ff + IdxBits'(1);
                  state_in = ST_ROW;
               end
            end
         end
         ST_COPY: begin
            if (delta_abs > chg_ff) chg_in = delta_abs;
            if (i_ff == last_idx) begin
               sweep_in = sweep_ff + 10'd1;
               state_in = ST_CHECK;
            end else begin
               i_in = i_ff + IdxBits'(1);
            end
         end
         ST_CHECK: begin
            i_in = '0;
            if (chg_ff > {1'b0, tol_ff} && sweep_ff < limit_ff) begin
               state_in = ST_ROW;
            end else begin
               status_in = (sweep_ff >= limit_ff) ? STATUS_NOCONV : STATUS_OK;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = i_ff;
               rsp_sol_in = (status_ff == STATUS_OK) ? cur_ff[i_ff] : '0;
               rsp_status_in = status_ff;
               rsp_last_in = (i_ff == last_idx);
               if (i_ff == last_idx) state_in = ST_DRAIN;
               else i_in = i_ff + IdxBits'(1);
            end
         end
         ST_DRAIN: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
         jv_ff <= 1'b0;
         i_ff <= '0;
         j_ff <= '0;
         sweep_ff <= '0;
         status_ff <= STATUS_OK;
         zero_diag_ff <= 1'b0;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         jv_ff <= (state_ff == ST_DIAG || state_ff == ST_MAC) && (j_ff != n_eff);
         i_ff <= i_in;
         j_ff <= j_in;
         sweep_ff <= sweep_in;
         status_ff <= status_in;
         zero_diag_ff <= zero_diag_in;
         flush_ff <= flush_in;
      end
      jd_ff <= j_ff[IdxBits-1:0];
      acc_ff <= acc_in;
      diag_ff <= diag_in;
      chg_ff <= chg_in;
      rsp_index_ff <= rsp_index_in;
      rsp_sol_ff <= rsp_sol_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff <= rsp_last_in;
   end

   // estimates: cleared at solve start, next written by divider, copied per sweep
   always_ff @(posedge clock) begin
      for (int k = 0; k < MaxUnknowns; k++) begin
         if (state_ff == ST_LOAD && req_take && req_final_item) cur_ff[k] <= '0;
      end
      if (state_ff == ST_COPY) cur_ff[i_ff] <= nxt_ff[i_ff];
      if (state_ff == ST_DIVW && drsp.done) nxt_ff[i_ff] <= drsp.quotient;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_solution = rsp_sol_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last_result = rsp_last_ff;
endmodule

// ===== sv/jis_checker.sv =====
module jis_checker import jis_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_final_item,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_index,
   input logic [1:0]  rsp_status,
   input logic signed [31:0] rsp_solution
);
   // a solve always blocks the next transfer
   a_final_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_final_item |=> req_stall)
      else $error("input not stalled after final item");

   // no results while loading
   a_no_rsp_when_open: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("result while input open");

   // failed runs report zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_solution == '0)
      else $error("nonzero solution on failure");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_index))
      else $error("stalled result changed");
endmodule

bind jacobi_iteration_solver jis_checker u_jis_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_final_item (req_final_item),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_index      (rsp_index),
   .rsp_status     (rsp_status),
   .rsp_solution   (rsp_solution)
);

// ===== test/jacobi_iteration_solver_tb.sv =====
`timescale 1ns / 100ps

module jacobi_iteration_solver_tb;
   import jis_pkg::*;

   typedef struct packed {
      logic [3:0]         index;
      logic signed [31:0] solution;
      logic [1:0]         status;
      logic               last;
   } solution_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = 1'b0;
   logic [3:0] req_row = '0;
   logic [3:0] req_col = '0;
   logic signed [31:0] req_value = '0;
   logic req_final_item = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [3:0] rsp_index;
   logic signed [31:0] rsp_solution;
   logic [1:0] rsp_status;
   logic rsp_last_result;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // shadow copy of the block: registers, stores and estimate
   longint tol_reg = 66;
   int limit_reg = 50;
   int size_reg = 16;
   longint coef_mem [256];
   longint rhs_mem [16];
   longint est [16];
   longint nxt [16];

   solution_type pending_solutions [$];
   int errors = 0;
   bit idle_on = 1'b1;
   int wd_count = 0;
   int stall_hold = 0;

   jacobi_iteration_solver i_dut (.*);

   always #5 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int eff_size();
      if (size_reg == 0) return 1;
      if (size_reg > MaxUnknowns) return MaxUnknowns;
      return size_reg;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint exp);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
      errors++;
   endtask

   // Jacobi sweeps over the shadow system; queues one solution per unknown
   task automatic predict_solutions();
      int n;
      int sweeps;
      logic [1:0] st;
      longint num;
      longint q;
      longint chg;
      longint big;
      solution_type s;
      n = eff_size();
      st = STATUS_OK;
      for (int i = 0; i < n; i++) est[i] = 0;
      for (int i = 0; i < n; i++)
         if (coef_mem[i*16+i] == 0) st = STATUS_ZERODIAG;
      if (st == STATUS_OK) begin
         sweeps = 0;
         do begin
            for (int i = 0; i < n; i++) begin
               num = rhs_mem[i];
               for (int j = 0; j < n; j++)
                  if (j != i) num -= (coef_mem[i*16+j] * est[j]) >>> 16;
               if (num > (64'sd1 <<< 46)) num = 64'sd1 <<< 46;
               if (num < -(64'sd1 <<< 46)) num = -(64'sd1 <<< 46);
               q = (num * 65536) / coef_mem[i*16+i];
               if (q > 64'sd2147483647) q = 64'sd2147483647;
               if (q < -64'sd2147483648) q = -64'sd2147483648;
               nxt[i] = q;
            end
            big = 0;
            for (int i = 0; i < n; i++) begin
               chg = est[i] - nxt[i];
               if (chg < 0) chg = -chg;
               if (chg > big) big = chg;
               est[i] = nxt[i];
            end
            sweeps = (sweeps + 1) & 10'h3ff;
         end while (big > tol_reg && sweeps < limit_reg);
         if (sweeps >= limit_reg) st = STATUS_NOCONV;
      end
      for (int i = 0; i < n; i++) begin
         s.index = i[3:0];
         s.solution = (st == STATUS_OK) ? est[i][31:0] : 32'sd0;
         s.status = st;
         s.last = (i == n - 1);
         pending_solutions = {pending_solutions, s};
      end
   endtask

   // one load transfer; leaves valid high so a following item can go back to back
   task automatic send_item(input logic op, input int row, input int col,
                            input logic [31:0] value, input logic fin);
      int g;
      g = gap_len();
      if (g > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_op = op;
      req_row = row[3:0];
      req_col = col[3:0];
      req_value = value;
      req_final_item = fin;
      do @(posedge clock); while (!(req_valid && !req_stall));
      if (op == 1'b0) begin
         coef_mem[row*16+col] = $signed(value);
      end else begin
         rhs_mem[row] = $signed(value);
      end
      if (fin) predict_solutions();
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid = 1'b0;
      req_final_item = 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_solutions.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // register write, only once the solver has drained
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      end_burst();
      wait_idle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         CSR_TOLERANCE: tol_reg = data[30:0];
         CSR_SWEEP_LIMIT: limit_reg = data[9:0];
         CSR_SIZE: size_reg = data[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [31:0] diag_value(input int n);
      int v;
      v = (n + 1 + $urandom_range(0, 3)) * 65536 + $urandom_range(0, 65535);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic logic [31:0] off_value();
      return $urandom_range(0, 131072) - 65536;
   endfunction

   function automatic logic [31:0] rhs_value();
      return $urandom_range(0, 40 * 65536) - 20 * 65536;
   endfunction

   // full load of the first n rows in shuffled order, final flag on the last transfer
   task automatic load_system(input int n, input bit dominant);
      int ops [$];
      int rows [$];
      int cols [$];
      int k;
      int t;
      logic [31:0] v;
      for (int r = 0; r < n; r++) begin
         ops = {ops, 1}; rows = {rows, r}; cols = {cols, int'($urandom_range(0, 15))};
         for (int c = 0; c < n; c++) begin
            ops = {ops, 0}; rows = {rows, r}; cols = {cols, c};
         end
      end
      for (int i = ops.size() - 1; i > 0; i--) begin
         k = $urandom_range(0, i);
         t = ops[i]; ops[i] = ops[k]; ops[k] = t;
         t = rows[i]; rows[i] = rows[k]; rows[k] = t;
         t = cols[i]; cols[i] = cols[k]; cols[k] = t;
      end
      for (int i = 0; i < ops.size(); i++) begin
         // stray writes outside the used block are kept but must not matter
         if (n < 16 && $urandom_range(0, 7) == 0)
            send_item(1'($urandom_range(0, 1)), $urandom_range(n, 15), $urandom_range(0, 15),
                      $urandom, 1'b0);
         if (!dominant) v = $urandom;
         else if (ops[i] == 1) v = rhs_value();
         else if (rows[i] == cols[i]) v = diag_value(n);
         else v = off_value();
         send_item(1'(ops[i]), rows[i], cols[i], v, i == ops.size() - 1);
      end
   endtask

   task automatic test_basic_solve();
      write_reg(CSR_SIZE, 2);
      write_reg(CSR_TOLERANCE, 66);
      write_reg(CSR_SWEEP_LIMIT, 50);
      load_system(2, 1'b1);
   endtask

   // one unknown with extreme values: saturating quotients both ways
   task automatic test_extremes();
      write_reg(CSR_SIZE, 1);
      send_item(1'b0, 0, 0, 32'sd1, 1'b0);
      send_item(1'b1, 0, 0, 32'h7fffffff, 1'b1);
      send_item(1'b1, 0, 0, 32'h80000000, 1'b1);
      send_item(1'b0, 0, 0, 32'h80000000, 1'b1);
      send_item(1'b0, 0, 0, 32'hffffffff, 1'b1);
      send_item(1'b1, 0, 9, 32'h00010000, 1'b1);
   endtask

   task automatic test_zero_diagonal();
      write_reg(CSR_SIZE, 2);
      send_item(1'b0, 1, 1, 32'sd0, 1'b1);
      send_item(1'b0, 1, 1, 32'h00030000, 1'b1);
   endtask

   task automatic test_sweep_limits();
      write_reg(CSR_SWEEP_LIMIT, 0);
      send_item(1'b1, 1, 0, 32'h00020000, 1'b1);
      write_reg(CSR_SWEEP_LIMIT, 1);
      send_item(1'b1, 0, 0, 32'hfffe0000, 1'b1);
      // tolerance with bit 31 set is masked to 31 bits
      write_reg(CSR_TOLERANCE, 32'hffffffff);
      write_reg(CSR_SWEEP_LIMIT, 10);
      send_item(1'b1, 0, 0, 32'h00050000, 1'b1);
   endtask

   task automatic test_random();
      int sizes [8] = '{3, 2, 5, 4, 0, 6, 1, 2};
      int tols [8] = '{66, 1, 66, 2147483647, 1000, 66, 1, 300};
      int limits [8] = '{50, 1023, 50, 10, 5, 20, 1023, 40};
      int sent;
      int n;
      for (int p = 0; p < 8; p++) begin
         idle_on = (p != 3);
         write_reg(CSR_SIZE, sizes[p]);
         write_reg(CSR_TOLERANCE, tols[p]);
         write_reg(CSR_SWEEP_LIMIT, limits[p]);
         n = eff_size();
         sent = 0;
         while (sent < 12) begin
            if (n > 8 && sent > 0) begin
               // re-solve after one altered right-hand side
               send_item(1'b1, $urandom_range(0, n - 1), 0, rhs_value(), 1'b1);
               sent += 24;
            end else begin
               load_system(n, (n <= 8 && limits[p] <= 50) ? ($urandom_range(0, 4) != 0) : 1'b1);
               sent += n * n + n;
               // broken sequence: a lone rewrite that triggers a new solve
               if ($urandom_range(0, 3) == 0)
                  send_item(1'b0, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                            off_value(), 1'b1);
            end
         end
      end
      idle_on = 1'b1;
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (stall_hold > 0) stall_hold--;
      else stall_hold = gap_len();
      rsp_stall = (stall_hold > 0);
   end

   // compare each result transfer with the oldest predicted solution
   always @(posedge clock) begin : check_rsp
      solution_type exp_s;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_solutions.size() == 0) begin
            report_mismatch("unexpected result, index", rsp_index, -1);
         end else begin
            exp_s = pending_solutions.pop_front();
            if (rsp_index !== exp_s.index) report_mismatch("index", rsp_index, exp_s.index);
            if (rsp_solution !== exp_s.solution)
               report_mismatch("solution", rsp_solution, exp_s.solution);
            if (rsp_status !== exp_s.status) report_mismatch("status", rsp_status, exp_s.status);
            if (rsp_last_result !== exp_s.last)
               report_mismatch("last_result", rsp_last_result, exp_s.last);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         wd_count = 0;
      else
         wd_count++;
      if (wd_count >= 1500000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_basic_solve();
      test_extremes();
      test_zero_diagonal();
      test_sweep_limits();
      test_random();
      end_burst();
      while (pending_solutions.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
